FILE: rtl/mceb_pkg.sv
// Shared types and constants for the monochrome color expansion blitter.
package mceb_pkg;

  localparam int unsigned VramAddrBitsDefault = 20;
  localparam int unsigned BytesPerPixel = 2;
  localparam int unsigned OutAddrW = 20;
  localparam int unsigned ColorW = 16;
  localparam int unsigned GeomW = 16;
  localparam int unsigned StartW = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FG_COLOR   = 3'd0,
    REG_ROW_BYTES  = 3'd1,
    REG_ROWS       = 3'd2,
    REG_STRIDE     = 3'd3,
    REG_DEST_START = 3'd4
  } reg_idx_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  typedef struct packed {
    logic [ColorW-1:0] fg_color;
    logic [GeomW-1:0]  row_bytes_minus_one;
    logic [GeomW-1:0]  rows_minus_one;
    logic [GeomW-1:0]  dest_stride;
    logic [StartW-1:0] dest_start;
  } cfg_t;

  typedef struct packed {
    logic [OutAddrW-1:0] pixel_address;
    logic                write_enable;
    logic                row_done;
    logic                busy_res;
    logic                last;
  } pix_t;

endpackage

FILE: rtl/mono_to_color_expansion_blit.sv
// Top level of the transparent monochrome to 16-bit color expansion blitter.
// A start transaction gives no result.
// A source word gives a pixel per cycle unless output stalls, via one shared address adder.
// The first pixel reaches the output register after the engine has entered its run state.
// The input is not ready while a word is being expanded.
// Synchronous active-low reset clears the configuration and control registers and idles.
module mono_to_color_expansion_blit #(
  parameter int unsigned VRAM_ADDR_BITS = mceb_pkg::VramAddrBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mceb_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mceb_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [mceb_pkg::WordW-1:0]      in_source_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mceb_pkg::OutAddrW-1:0]   out_pixel_address,
  output logic [mceb_pkg::ColorW-1:0]     out_pixel_color,
  output logic                            out_write_enable,
  output logic                            out_row_done,
  output logic                            out_busy_res,
  output logic                            out_last
);
  import mceb_pkg::*;

  cfg_t              cfg;
  pix_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;
  pix_t              out_pix_r;
  logic [ColorW-1:0] out_color_r;

  assign cfg_ready = 1'b1;

  mceb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mceb_engine #(
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_source_word (in_source_word),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_pix_r   <= res;
      out_color_r <= cfg.fg_color;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_pix_r.pixel_address;
  assign out_pixel_color   = out_color_r;
  assign out_write_enable  = out_pix_r.write_enable;
  assign out_row_done      = out_pix_r.row_done;
  assign out_busy_res      = out_pix_r.busy_res;
  assign out_last          = out_pix_r.last;

  a_idle_busy_clear_is_last: assert property (
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_busy_res) |-> out_last
  ) else $error("busy cleared on a pixel that is not the last of its word");

  a_ready_only_after_last: assert property (
    @(posedge clk) disable iff (!rst_n) (in_ready && out_valid) |-> out_last
  ) else $error("input ready while a word still has pixels pending");

  a_busy_clear_ends_row: assert property (
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_busy_res) |-> out_row_done
  ) else $error("busy cleared away from a row end");

endmodule

FILE: rtl/mceb_cfg.sv
// Configuration register file of the color expansion blitter.
module mceb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [mceb_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [mceb_pkg::CfgDataW-1:0] wr_data,
  output mceb_pkg::cfg_t                cfg
);
  import mceb_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FG_COLOR:   cfg_r.fg_color <= wr_data[ColorW-1:0];
        REG_ROW_BYTES:  cfg_r.row_bytes_minus_one <= wr_data[GeomW-1:0];
        REG_ROWS:       cfg_r.rows_minus_one <= wr_data[GeomW-1:0];
        REG_STRIDE:     cfg_r.dest_stride <= wr_data[GeomW-1:0];
        REG_DEST_START: cfg_r.dest_start <= wr_data[StartW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/mceb_engine.sv
// Pixel sequencer with one shared address adder, one pixel per step.
module mceb_engine #(
  parameter int unsigned VRAM_ADDR_BITS = mceb_pkg::VramAddrBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mceb_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [mceb_pkg::WordW-1:0]  in_source_word,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mceb_pkg::pix_t              res
);
  import mceb_pkg::*;

  localparam int unsigned AW = VRAM_ADDR_BITS;
  localparam int unsigned BlW = GeomW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        row_start_r, row_start_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [BlW-1:0]       bytes_left_r, bytes_left_nxt;
  logic [GeomW-1:0]     rows_left_r, rows_left_nxt;
  logic                 busy_r, busy_nxt;
  logic [WordW-1:0]     word_r, word_nxt;
  logic [1:0]           byte_idx_r, byte_idx_nxt;
  logic [2:0]           bit_idx_r, bit_idx_nxt;

  logic [7:0]           cur_byte;
  logic [BlW-1:0]       take;
  logic [BlW-1:0]       bl_after;
  logic                 row_end;
  logic                 byte_end;
  logic                 busy_after;
  logic                 last_pix;
  logic [AW-1:0]        add_a;
  logic [AW-1:0]        add_b;
  logic [AW-1:0]        add_sum;
  logic [AW-1:0]        start_addr;
  logic [AW-1:0]        stride_ext;
  logic [AW+OutAddrW-1:0] start_wide;
  logic [AW+GeomW-1:0]    stride_wide;
  logic [AW+OutAddrW-1:0] out_wide;
  logic                 step;

  assign start_wide  = {{AW{1'b0}}, cfg.dest_start};
  assign start_addr  = start_wide[AW-1:0];
  assign stride_wide = {{AW{1'b0}}, cfg.dest_stride};
  assign stride_ext  = stride_wide[AW-1:0];
  assign out_wide    = {{OutAddrW{1'b0}}, ptr_r};

  assign cur_byte = word_r[byte_idx_r*8 +: 8];
  assign take     = (bytes_left_r >= BlW'(BytesPerPixel)) ? BlW'(BytesPerPixel) : bytes_left_r;
  assign bl_after = bytes_left_r - take;
  assign row_end  = (bl_after == '0);
  assign byte_end = row_end || (bit_idx_r == 3'd0);
  assign busy_after = !(row_end && (rows_left_r == '0));
  assign last_pix = !busy_after || (byte_end && (byte_idx_r == 2'd3));

  assign add_a   = row_end ? row_start_r : ptr_r;
  assign add_b   = row_end ? stride_ext : AW'(BytesPerPixel);
  assign add_sum = add_a + add_b;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RUN);
  assign step      = res_valid && res_ready;

  assign res.pixel_address = out_wide[OutAddrW-1:0];
  assign res.write_enable  = cur_byte[bit_idx_r];
  assign res.row_done      = row_end;
  assign res.busy_res      = busy_after;
  assign res.last          = last_pix;

  always_comb begin
    state_nxt      = state_r;
    row_start_nxt  = row_start_r;
    ptr_nxt        = ptr_r;
    bytes_left_nxt = bytes_left_r;
    rows_left_nxt  = rows_left_r;
    busy_nxt       = busy_r;
    word_nxt       = word_r;
    byte_idx_nxt   = byte_idx_r;
    bit_idx_nxt    = bit_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_START) begin
            row_start_nxt  = start_addr;
            ptr_nxt        = start_addr;
            bytes_left_nxt = {1'b0, cfg.row_bytes_minus_one} + BlW'(1);
            rows_left_nxt  = cfg.rows_minus_one;
            busy_nxt       = 1'b1;
          end else if (busy_r) begin
            word_nxt     = in_source_word;
            byte_idx_nxt = 2'd0;
            bit_idx_nxt  = 3'd7;
            state_nxt    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (step) begin
          if (row_end) begin
            row_start_nxt  = add_sum;
            ptr_nxt        = add_sum;
            bytes_left_nxt = {1'b0, cfg.row_bytes_minus_one} + BlW'(1);
            if (rows_left_r != '0) begin
              rows_left_nxt = rows_left_r - GeomW'(1);
            end
            busy_nxt = busy_after;
          end else begin
            ptr_nxt        = add_sum;
            bytes_left_nxt = bl_after;
          end
          if (byte_end) begin
            byte_idx_nxt = byte_idx_r + 2'd1;
            bit_idx_nxt  = 3'd7;
          end else begin
            bit_idx_nxt = bit_idx_r - 3'd1;
          end
          if (last_pix) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_start_r  <= '0;
      ptr_r        <= '0;
      bytes_left_r <= '0;
      rows_left_r  <= '0;
      busy_r       <= 1'b0;
      byte_idx_r   <= '0;
      bit_idx_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      row_start_r  <= row_start_nxt;
      ptr_r        <= ptr_nxt;
      bytes_left_r <= bytes_left_nxt;
      rows_left_r  <= rows_left_nxt;
      busy_r       <= busy_nxt;
      byte_idx_r   <= byte_idx_nxt;
      bit_idx_r    <= bit_idx_nxt;
    end
    word_r <= word_nxt;
  end

endmodule
